### hw/rtl/ordered_queue_with_keyed_removal_assert.svh
// ============================================================================
// Assertion macros for the ordered queue with keyed removal
// Concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ============================================================================
`ifndef ORDERED_QUEUE_WITH_KEYED_REMOVAL_ASSERT_SVH
`define ORDERED_QUEUE_WITH_KEYED_REMOVAL_ASSERT_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define OQKR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define OQKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OQKR_ASSERT(label, clk, rst, prop, msg)
`define OQKR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/oqkr_pkg.sv
// ============================================================================
// Ordered queue package
// Shared widths, opcodes, status codes and control types.
// ============================================================================
`default_nettype none

package oqkr_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W     = 2;
   localparam int ST_W     = 2;
   localparam int HANDLE_W = 16;
   localparam int ID_W     = 16;
   localparam int CNT_OUT_W = 5;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [ST_W-1:0]     status_type;
   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [ID_W-1:0]     id_type;

   localparam opcode_type OP_APPEND    = 2'd0;
   localparam opcode_type OP_RM_HANDLE = 2'd1;
   localparam opcode_type OP_RM_ID     = 2'd2;
   localparam opcode_type OP_POP       = 2'd3;

   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;
   localparam status_type ST_NULL = 2'd3;

   typedef struct packed {
      logic load;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/oqkr_channels.sv
// ============================================================================
// Ordered queue channels
// Valid/ready request and response transaction interfaces.
// ============================================================================
`default_nettype none

interface oqkr_req_if import oqkr_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   handle_type item_handle;
   id_type     key_id;

   modport source (output valid, output opcode, output item_handle, output key_id,
                   input ready);
   modport sink   (input valid, input opcode, input item_handle, input key_id,
                   output ready);
endinterface

interface oqkr_rsp_if import oqkr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   handle_type           out_handle;
   id_type               out_id;
   logic [CNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output out_handle, output out_id,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input out_handle, input out_id,
                   input entry_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/ordered_queue_with_keyed_removal.sv
// A request transaction is accepted into the load registers; its response is registered at the commit step.
// A new transaction is not accepted until the accept/commit sequencer has committed the last one.
// A response left waiting holds the commit step until it is taken.
// Reset (synchronous, active high) empties the queue and drops a pending response.
// ============================================================================
// Ordered queue with keyed removal
// FIFO of handle/id entries with append, pop and removal by handle or id.
// ============================================================================
`default_nettype none

`include "ordered_queue_with_keyed_removal_assert.svh"

module ordered_queue_with_keyed_removal import oqkr_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   oqkr_req_if.sink   req_chan,
   oqkr_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   ctrl_cmd_type     cmd;
   dp_status_type    dp_status;
   logic [CNT_W-1:0] count;

   oqkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   oqkr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_opcode      (req_chan.opcode),
      .req_item_handle (req_chan.item_handle),
      .req_key_id      (req_chan.key_id),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_out_handle  (rsp_chan.out_handle),
      .rsp_out_id      (rsp_chan.out_id),
      .rsp_entry_count (rsp_chan.entry_count),
      .count           (count)
   );

   `OQKR_ASSERT(a_count_range, clock, reset, count <= CNT_W'(DEPTH), "entry count above depth")
   `OQKR_ASSERT_NEXT(a_commit_rsp, clock, reset, cmd.commit, rsp_chan.valid, "commit without response")
   `OQKR_ASSERT_NEXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "accepted while busy")
   `OQKR_ASSERT(a_no_commit_blocked, clock, reset, !(cmd.commit && rsp_chan.valid && !rsp_chan.ready), "response overwritten")

endmodule

`default_nettype wire

### hw/rtl/oqkr_ctrl.sv
// ============================================================================
// Ordered queue controller
// Two-state sequencer: accept a transaction, then commit it to the queue.
// ============================================================================
`default_nettype none

module oqkr_ctrl import oqkr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type dp_status,
   output ctrl_cmd_type       cmd
);

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_COMMIT = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (dp_status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/oqkr_dpath.sv
// ============================================================================
// Ordered queue datapath
// Entry cells with per-cell match, first-hit compaction and result register.
// ============================================================================
`default_nettype none

module oqkr_dpath import oqkr_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      dp_status,
   input  wire opcode_type    req_opcode,
   input  wire handle_type    req_item_handle,
   input  wire id_type        req_key_id,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output status_type         rsp_status,
   output handle_type         rsp_out_handle,
   output id_type             rsp_out_id,
   output logic [CNT_OUT_W-1:0] rsp_entry_count,
   output logic [CNT_W-1:0]   count
);

   handle_type slot_handle_ff [DEPTH];
   handle_type slot_handle_in [DEPTH];
   id_type     slot_id_ff     [DEPTH];
   id_type     slot_id_in     [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [DEPTH-1:0] match_ff, match_in;
   opcode_type       op_ff;
   handle_type       hnd_ff;
   id_type           key_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   handle_type       rsp_handle_ff, rsp_handle_in;
   id_type           rsp_id_ff, rsp_id_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DEPTH-1:0] neg_match, first_hit, at_or_after;
   logic             any_hit, is_null, do_append, do_remove;
   handle_type       sel_handle;
   id_type           sel_id;

   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;
   assign count = count_ff;

   // per-cell compare against the incoming request
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = 1'b0;
         if (count_ff > CNT_W'(i)) begin
            case (req_opcode)
               OP_RM_HANDLE: match_in[i] = (slot_handle_ff[i] == req_item_handle);
               OP_RM_ID:     match_in[i] = (slot_id_ff[i] == req_key_id);
               OP_POP:       match_in[i] = (i == 0);
               default:      match_in[i] = 1'b0;
            endcase
         end
      end
   end

   assign neg_match   = ~match_ff + DEPTH'(1);
   assign first_hit   = match_ff & neg_match;
   assign at_or_after = match_ff | neg_match;
   assign any_hit     = |match_ff;

   always_comb begin
      sel_handle = '0;
      sel_id     = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_handle = sel_handle | (slot_handle_ff[i] & {HANDLE_W{first_hit[i]}});
         sel_id     = sel_id | (slot_id_ff[i] & {ID_W{first_hit[i]}});
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_APPEND:    is_null = (hnd_ff == '0) || (key_ff == '0);
         OP_RM_HANDLE: is_null = (hnd_ff == '0);
         OP_RM_ID:     is_null = (key_ff == '0);
         OP_POP:       is_null = 1'b0;
         default:      is_null = 1'b0;
      endcase
   end

   always_comb begin
      do_append     = 1'b0;
      do_remove     = 1'b0;
      rsp_status_in = ST_OK;
      rsp_handle_in = '0;
      rsp_id_in     = '0;
      count_in      = count_ff;
      if (is_null) begin
         rsp_status_in = ST_NULL;
      end else if (op_ff == OP_APPEND) begin
         if (count_ff == CNT_W'(DEPTH)) begin
            rsp_status_in = ST_FULL;
         end else begin
            do_append = 1'b1;
            count_in  = count_ff + CNT_W'(1);
         end
      end else if (!any_hit) begin
         rsp_status_in = ST_MISS;
      end else begin
         do_remove     = 1'b1;
         rsp_handle_in = sel_handle;
         rsp_id_in     = sel_id;
         count_in      = count_ff - CNT_W'(1);
      end
      rsp_count_in = CNT_OUT_W'(count_in);
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      always_comb begin
         slot_handle_in[g] = slot_handle_ff[g];
         slot_id_in[g]     = slot_id_ff[g];
         if (cmd.commit) begin
            if (do_append && (count_ff == CNT_W'(g))) begin
               slot_handle_in[g] = hnd_ff;
               slot_id_in[g]     = key_ff;
            end else if (do_remove && at_or_after[g]) begin
               if (g < DEPTH - 1) begin
                  slot_handle_in[g] = slot_handle_ff[(g + 1) % DEPTH];
                  slot_id_in[g]     = slot_id_ff[(g + 1) % DEPTH];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         slot_handle_ff[g] <= slot_handle_in[g];
         slot_id_ff[g]     <= slot_id_in[g];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         match_ff <= match_in;
         op_ff    <= req_opcode;
         hnd_ff   <= req_item_handle;
         key_ff   <= req_key_id;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_handle  = rsp_handle_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire
